[src/lss_pkg.sv]
// Shared constants, codes and types for the LIFO stack with search.
package lss_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Request codes
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;
    localparam logic [1:0] MODE_SEARCH = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EMIT
    } t_state;

    // One result item
    typedef struct packed {
        logic [1:0]            status;
        logic [WORD_WIDTH-1:0] data;
        logic [ADDR_W-1:0]     index;
        logic [CNT_W-1:0]      count;
        logic                  empty;
    } t_result;

endpackage

[src/lss_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module lss_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/lss_core.sv]
// Request sequencer: word count, memory access control and bottom-up search scan.
module lss_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [lss_pkg::WORD_WIDTH-1:0]      i_value,
    // memory port
    output logic                                o_we,
    output logic [lss_pkg::ADDR_W-1:0]          o_waddr,
    output logic [lss_pkg::WORD_WIDTH-1:0]      o_wdata,
    output logic                                o_re,
    output logic [lss_pkg::ADDR_W-1:0]          o_raddr,
    input  logic [lss_pkg::WORD_WIDTH-1:0]      i_rdata,
    // result toward output register
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output lss_pkg::t_result                    o_res
);

    lss_pkg::t_state                   r_state, n_state;
    logic [lss_pkg::CNT_W-1:0]         r_count, n_count;
    logic [lss_pkg::WORD_WIDTH-1:0]    r_key, n_key;
    logic [lss_pkg::ADDR_W-1:0]        r_ptr, n_ptr;
    lss_pkg::t_result                  r_res, n_res;

    logic                              w_accept;
    logic                              w_empty;
    logic                              w_full;
    logic [lss_pkg::CNT_W-1:0]         w_cnt_inc;
    logic [lss_pkg::CNT_W-1:0]         w_cnt_dec;
    logic [lss_pkg::CNT_W-1:0]         w_ptr_next;
    logic                              w_match;
    logic                              w_last;
    logic                              w_take;

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == lss_pkg::CNT_W'(lss_pkg::DEPTH));
    assign w_cnt_inc  = r_count + lss_pkg::CNT_W'(1);
    assign w_cnt_dec  = r_count - lss_pkg::CNT_W'(1);
    assign w_ptr_next = {1'b0, r_ptr} + lss_pkg::CNT_W'(1);
    assign w_match    = (i_rdata == r_key);
    assign w_last     = (w_ptr_next == r_count);
    assign w_take     = (r_state == lss_pkg::S_EMIT) && i_res_ready;

    // Take a new request when idle, or as the pending result leaves
    assign o_in_stall = !((r_state == lss_pkg::S_IDLE) || w_take);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lss_pkg::S_IDLE: n_state = lss_pkg::S_IDLE;
            lss_pkg::S_READ: n_state = lss_pkg::S_EMIT;
            lss_pkg::S_SCAN: begin
                if (w_match || w_last) begin
                    n_state = lss_pkg::S_EMIT;
                end
            end
            lss_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    n_state = lss_pkg::S_IDLE;
                end
            end
            default: n_state = lss_pkg::S_IDLE;
        endcase
        if (w_accept) begin
            case (i_mode)
                lss_pkg::MODE_PUSH: n_state = lss_pkg::S_EMIT;
                lss_pkg::MODE_POP,
                lss_pkg::MODE_PEEK: n_state = w_empty ? lss_pkg::S_EMIT : lss_pkg::S_READ;
                lss_pkg::MODE_SEARCH: n_state = w_empty ? lss_pkg::S_EMIT : lss_pkg::S_SCAN;
                default: n_state = lss_pkg::S_EMIT;
            endcase
        end
    end

    // Memory control and datapath next values
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_count[lss_pkg::ADDR_W-1:0];
        o_wdata = i_value;
        o_re    = 1'b0;
        o_raddr = w_ptr_next[lss_pkg::ADDR_W-1:0];
        n_count = r_count;
        n_key   = r_key;
        n_ptr   = r_ptr;
        n_res   = r_res;

        // Work on the request in flight
        case (r_state)
            lss_pkg::S_READ: begin
                n_res.data = i_rdata;
            end
            lss_pkg::S_SCAN: begin
                if (w_match) begin
                    n_res.status = lss_pkg::STAT_OK;
                    n_res.index  = r_ptr;
                end else if (!w_last) begin
                    o_re  = 1'b1;
                    n_ptr = w_ptr_next[lss_pkg::ADDR_W-1:0];
                end
            end
            default: ;
        endcase

        // New request
        if (w_accept) begin
            n_res.status = lss_pkg::STAT_OK;
            n_res.data   = '0;
            n_res.index  = '0;
            case (i_mode)
                lss_pkg::MODE_PUSH: begin
                    if (w_full) begin
                        n_res.status = lss_pkg::STAT_FULL;
                    end else begin
                        o_we    = 1'b1;
                        n_count = w_cnt_inc;
                    end
                end
                lss_pkg::MODE_POP: begin
                    if (w_empty) begin
                        n_res.status = lss_pkg::STAT_EMPTY;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = w_cnt_dec[lss_pkg::ADDR_W-1:0];
                        n_count = w_cnt_dec;
                    end
                end
                lss_pkg::MODE_PEEK: begin
                    if (w_empty) begin
                        n_res.status = lss_pkg::STAT_EMPTY;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = w_cnt_dec[lss_pkg::ADDR_W-1:0];
                    end
                end
                default: begin
                    // search starts at the bottom entry
                    n_res.status = lss_pkg::STAT_NOT_FOUND;
                    n_key        = i_value;
                    n_ptr        = '0;
                    if (!w_empty) begin
                        o_re    = 1'b1;
                        o_raddr = '0;
                    end
                end
            endcase
            n_res.count = n_count;
            n_res.empty = (n_count == '0);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lss_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_ptr <= n_ptr;
        r_res <= n_res;
    end

    assign o_res_valid = (r_state == lss_pkg::S_EMIT);
    assign o_res       = r_res;

endmodule

[src/lss_outbuf.sv]
// Output register that holds one result until the downstream side takes it.
module lss_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    output logic             o_res_ready,
    input  lss_pkg::t_result i_res,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lss_pkg::t_result o_res
);

    logic             r_valid;
    lss_pkg::t_result r_res;

    // Room when empty or when the held result transfers this cycle
    assign o_res_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

[src/lifo_stack_with_search.sv]
// Top level of the LIFO stack with search: sequencer, stack memory and output register.
// Push and any request on an empty stack go straight to the result; pop and peek read RAM first.
// Throughput: push one per cycle while the output is not stalled; a pop or peek reading a word
// waits for its RAM read. Search holds the input while it scans up, one RAM read per cycle.
// Reset (synchronous, active low) empties the stack and drops any pending result;
// the memory itself is not cleared, and no clearing pass is needed.
module lifo_stack_with_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_data_out,
    output logic [5:0]  o_found_index,
    output logic [6:0]  o_count_out,
    output logic        o_is_empty
);

    logic                               w_we;
    logic [lss_pkg::ADDR_W-1:0]         w_waddr;
    logic [lss_pkg::WORD_WIDTH-1:0]     w_wdata;
    logic                               w_re;
    logic [lss_pkg::ADDR_W-1:0]         w_raddr;
    logic [lss_pkg::WORD_WIDTH-1:0]     w_rdata;
    logic                               w_res_valid;
    logic                               w_res_ready;
    lss_pkg::t_result                   w_res;
    lss_pkg::t_result                   w_out;

    // Request sequencer
    lss_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Stack storage
    lss_ram #(
        .DEPTH (lss_pkg::DEPTH),
        .WIDTH (lss_pkg::WORD_WIDTH),
        .AW    (lss_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result register
    lss_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_out)
    );

    assign o_status      = w_out.status;
    assign o_data_out    = w_out.data;
    assign o_found_index = w_out.index;
    assign o_count_out   = w_out.count;
    assign o_is_empty    = w_out.empty;

endmodule

[src/lss_checker.sv]
// Port-level checks for the LIFO stack with search, bound to the top level.
module lss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_data_out,
    input logic [5:0]  o_found_index,
    input logic [6:0]  o_count_out,
    input logic        o_is_empty
);

    // Empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_count_out == 7'd0)))
        else $error("is_empty disagrees with count_out");

    // A full report only comes with a full stack
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lss_pkg::STAT_FULL))
            |-> (o_count_out == 7'(lss_pkg::DEPTH)))
        else $error("full status with stack not full");

    // An empty report only comes with an empty stack and no data
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lss_pkg::STAT_EMPTY))
            |-> (o_is_empty && (o_data_out == 32'd0)))
        else $error("empty status with words stored or data");

    // Failed search gives zero index and zero data
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lss_pkg::STAT_NOT_FOUND))
            |-> ((o_found_index == 6'd0) && (o_data_out == 32'd0)))
        else $error("not-found result carries index or data");

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_data_out) && $stable(o_found_index) && $stable(o_count_out)))
        else $error("stalled result changed");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the LIFO stack with search: random requests against a stack model.
module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [31:0] o_data_out;
    logic [5:0]  o_found_index;
    logic [6:0]  o_count_out;
    logic        o_is_empty;

    // Stack model: words and fill level after every accepted request
    logic [lss_pkg::WORD_WIDTH-1:0] model_words [lss_pkg::DEPTH];
    int                             model_count;

    lss_pkg::t_result expected_results[$];
    int               mismatch_count;
    bit               no_idle;

    lifo_stack_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_count_out   (o_count_out),
        .o_is_empty    (o_is_empty)
    );

    // 10-unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the stack model and queue the result it must produce
    function automatic void stack_model_apply(input logic [1:0] mode, input logic [31:0] val);
        lss_pkg::t_result r;
        r        = '0;
        r.status = lss_pkg::STAT_OK;
        case (mode)
            lss_pkg::MODE_PUSH: begin
                if (model_count >= lss_pkg::DEPTH) begin
                    r.status = lss_pkg::STAT_FULL;
                end else begin
                    model_words[model_count] = val[lss_pkg::WORD_WIDTH-1:0];
                    model_count++;
                end
            end
            lss_pkg::MODE_POP: begin
                if (model_count == 0) begin
                    r.status = lss_pkg::STAT_EMPTY;
                end else begin
                    model_count--;
                    r.data = model_words[model_count];
                end
            end
            lss_pkg::MODE_PEEK: begin
                if (model_count == 0)
                    r.status = lss_pkg::STAT_EMPTY;
                else
                    r.data = model_words[model_count-1];
            end
            default: begin
                // lowest matching index wins, scanning up from the bottom
                r.status = lss_pkg::STAT_NOT_FOUND;
                for (int i = 0; i < model_count; i++) begin
                    if (model_words[i] == val[lss_pkg::WORD_WIDTH-1:0]) begin
                        r.status = lss_pkg::STAT_OK;
                        r.index  = lss_pkg::ADDR_W'(i);
                        break;
                    end
                end
            end
        endcase
        r.count = lss_pkg::CNT_W'(model_count);
        r.empty = (model_count == 0);
        expected_results.push_back(r);
    endfunction

    // Word mix: full random, a small pool for duplicates, and the extremes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Search key: mostly a word held in the stack, otherwise any word
    function automatic logic [31:0] rand_key();
        if (model_count > 0 && $urandom_range(0, 99) < 60)
            return model_words[$urandom_range(0, model_count - 1)];
        return rand_word();
    endfunction

    // One request transfer; idle cycles carry random junk on the payload
    task automatic send_req(input logic [1:0] mode, input logic [31:0] val);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            i_mode     <= 2'($urandom);
            i_value    <= $urandom;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        stack_model_apply(mode, val);
    endtask

    // Drop the request and hold off until every queued result has been checked
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side stall
    always @(negedge i_clk)
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 13);

    // Check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        lss_pkg::t_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h", $time, o_status,
                         o_data_out);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             o_status);
                    mismatch_count++;
                end
                if (o_data_out !== exp_r.data) begin
                    $display("%0t: data_out expected %h actual %h", $time, exp_r.data,
                             o_data_out);
                    mismatch_count++;
                end
                if (o_found_index !== exp_r.index) begin
                    $display("%0t: found_index expected %0d actual %0d", $time, exp_r.index,
                             o_found_index);
                    mismatch_count++;
                end
                if (o_count_out !== exp_r.count) begin
                    $display("%0t: count_out expected %0d actual %0d", $time, exp_r.count,
                             o_count_out);
                    mismatch_count++;
                end
                if (o_is_empty !== exp_r.empty) begin
                    $display("%0t: is_empty expected %0b actual %0b", $time, exp_r.empty,
                             o_is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Pop, peek and search on an empty stack
    task automatic test_empty_stack();
        send_req(lss_pkg::MODE_POP, 32'h0);
        send_req(lss_pkg::MODE_PEEK, 32'h0);
        send_req(lss_pkg::MODE_SEARCH, 32'h0);
        send_req(lss_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
    endtask

    // Extremes, duplicates and every operation on a short stack
    task automatic test_basic_ops();
        send_req(lss_pkg::MODE_PUSH, 32'h0000_0000);
        send_req(lss_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_req(lss_pkg::MODE_PUSH, 32'hA5A5_5A5A);
        send_req(lss_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_req(lss_pkg::MODE_PEEK, 32'h0);
        send_req(lss_pkg::MODE_SEARCH, 32'hFFFF_FFFF);   // duplicate: lowest index
        send_req(lss_pkg::MODE_SEARCH, 32'h0000_0000);
        send_req(lss_pkg::MODE_SEARCH, 32'h1234_5678);   // absent key
        send_req(lss_pkg::MODE_POP, 32'h0);
        send_req(lss_pkg::MODE_POP, 32'h0);
        send_req(lss_pkg::MODE_SEARCH, 32'hA5A5_5A5A);   // popped, no longer found
        send_req(lss_pkg::MODE_POP, 32'h0);
        send_req(lss_pkg::MODE_POP, 32'h0);
        send_req(lss_pkg::MODE_POP, 32'h0);              // empty again
        send_req(lss_pkg::MODE_PEEK, 32'h0);
    endtask

    // Fill to full, push past full, search across the whole stack, then drain it
    task automatic test_fill_and_drain();
        while (model_count < lss_pkg::DEPTH)
            send_req(lss_pkg::MODE_PUSH, rand_word());
        repeat (3) send_req(lss_pkg::MODE_PUSH, rand_word());
        send_req(lss_pkg::MODE_PEEK, 32'h0);
        send_req(lss_pkg::MODE_SEARCH, model_words[lss_pkg::DEPTH-1]);
        send_req(lss_pkg::MODE_SEARCH, model_words[0]);
        send_req(lss_pkg::MODE_SEARCH, rand_key());
        send_req(lss_pkg::MODE_SEARCH, $urandom);
        // sender waits for every result before the pop run
        wait_results_drained();
        while (model_count > 0) begin
            if ($urandom_range(0, 9) == 0)
                send_req(lss_pkg::MODE_SEARCH, rand_key());
            else
                send_req(lss_pkg::MODE_POP, 32'h0);
        end
        send_req(lss_pkg::MODE_POP, 32'h0);
    endtask

    // Random mix with alternating grow, shrink and balanced phases
    task automatic test_random_mix(input int n_items, input int quiet_items);
        int          roll;
        int          push_w;
        int          pop_w;
        logic [1:0]  mode;
        logic [31:0] val;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k < quiet_items);
            case ((k / 120) % 3)
                0: begin push_w = 55; pop_w = 15; end
                1: begin push_w = 15; pop_w = 55; end
                default: begin push_w = 30; pop_w = 30; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_w)
                mode = lss_pkg::MODE_PUSH;
            else if (roll < push_w + pop_w)
                mode = lss_pkg::MODE_POP;
            else if (roll < push_w + pop_w + 12)
                mode = lss_pkg::MODE_PEEK;
            else
                mode = lss_pkg::MODE_SEARCH;
            val = (mode == lss_pkg::MODE_SEARCH) ? rand_key() :
                  (mode == lss_pkg::MODE_PUSH)   ? rand_word() : $urandom;
            send_req(mode, val);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = lss_pkg::MODE_PUSH;
        i_value        = '0;
        i_out_stall    = 1'b0;
        model_count    = 0;
        mismatch_count = 0;
        no_idle        = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_stack();
        test_basic_ops();
        test_fill_and_drain();
        test_random_mix(1600, 300);
        test_fill_and_drain();

        wait_results_drained();
        repeat (lss_pkg::DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
